// ----- hdl/sew_pkg.sv -----
package sew_pkg;

    // Default frame shape of the encoder reader.
    localparam int unsigned RAW_BITS_DEF        = 12;
    localparam int unsigned FRAME_TICKS_DEF     = 40;
    localparam int unsigned LAST_CLOCK_TICK_DEF = 37;

    // Fixed widths of the frame counters and the payload.
    localparam int unsigned PHASE_W = 6;
    localparam int unsigned COUNT_W = 5;
    localparam int unsigned WIDTH_W = 16;
    localparam int unsigned ANGLE_W = 9;
    localparam int unsigned SPAN_W  = WIDTH_W + 1;
    localparam int unsigned NUM_W   = 27;
    localparam int unsigned QNUM_W  = 25;

    // First tick on which a falling serial clock edge samples data.
    localparam int unsigned FIRST_SAMPLE_TICK = 3;
    // Bit count saturates here.
    localparam int unsigned COUNT_MAX = 31;

    // Degrees in a full and a half turn.
    localparam int unsigned DEG_FULL = 360;
    localparam int unsigned DEG_HALF = 180;

    // Division of the width numerator by 360: multiply by a reciprocal, shift,
    // then one correction step. Numerators at or above SAT_NUM saturate.
    localparam int unsigned RECIP_MUL   = 186413;
    localparam int unsigned RECIP_SHIFT = 26;
    localparam int unsigned RECIP_PROD_W = QNUM_W + 18;
    localparam logic signed [NUM_W-1:0] SAT_NUM = 27'sd23592960;

    // Configuration register indexes and reset values.
    localparam logic [1:0] CFG_CENTER = 2'd0;
    localparam logic [1:0] CFG_LEFT   = 2'd1;
    localparam logic [1:0] CFG_RIGHT  = 2'd2;
    localparam logic [WIDTH_W-1:0] CENTER_RST = 16'd28000;
    localparam logic [WIDTH_W-1:0] LEFT_RST   = 16'd10000;
    localparam logic [WIDTH_W-1:0] RIGHT_RST  = 16'd46000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;    // accept one tick and advance the frame state
        logic angle;   // convert the raw word to degrees
        logic num;     // form the width numerator
        logic recip;   // reciprocal multiply of the numerator
        logic load;    // finish the width and load the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic frame_end;  // the tick now offered ends the frame
        logic out_free;   // the output register can take a new result
    } t_stat;

endpackage

// ----- hdl/sew_ctrl.sv -----
module sew_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  sew_pkg::t_stat i_stat,
    output sew_pkg::t_cmd  o_cmd,
    output logic          o_stall
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_ANGLE = 3'd1;
    localparam logic [2:0] ST_NUM   = 3'd2;
    localparam logic [2:0] ST_RECIP = 3'd3;
    localparam logic [2:0] ST_FIX   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    // Sequencer: ordinary ticks go straight to the output load, frame-end
    // ticks run through the three arithmetic steps first.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = i_stat.frame_end ? ST_ANGLE : ST_FIX;
                end
            end
            ST_ANGLE: begin
                o_cmd.angle = 1'b1;
                n_state     = ST_NUM;
            end
            ST_NUM: begin
                o_cmd.num = 1'b1;
                n_state   = ST_RECIP;
            end
            ST_RECIP: begin
                o_cmd.recip = 1'b1;
                n_state     = ST_FIX;
            end
            ST_FIX: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Input is taken only while the sequencer waits for a tick.
    assign o_stall = (r_state != ST_IDLE);

endmodule

// ----- hdl/sew_datapath.sv -----
module sew_datapath #(
    parameter int unsigned RAW_BITS        = sew_pkg::RAW_BITS_DEF,
    parameter int unsigned FRAME_TICKS     = sew_pkg::FRAME_TICKS_DEF,
    parameter int unsigned LAST_CLOCK_TICK = sew_pkg::LAST_CLOCK_TICK_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  sew_pkg::t_cmd         i_cmd,
    output sew_pkg::t_stat        o_stat,
    input  logic                 i_data_in,
    input  logic                 i_cfg_wr_en,
    input  logic [1:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_stall,
    output logic                 o_valid,
    output logic                 o_select_out,
    output logic                 o_clock_out,
    output logic                 o_angle_valid,
    output logic signed [8:0]    o_angle_deg,
    output logic [15:0]          o_servo_width,
    output logic                 o_parity_bit
);

    localparam int unsigned PW = sew_pkg::PHASE_W;
    localparam int unsigned CW = sew_pkg::COUNT_W;
    localparam int unsigned AP_W = RAW_BITS + sew_pkg::ANGLE_W;
    localparam int unsigned RS = sew_pkg::RECIP_SHIFT;

    // Configuration registers.
    logic [15:0] r_center;
    logic [15:0] r_left;
    logic [15:0] r_right;

    // Frame state.
    logic [PW-1:0]       r_phase;
    logic                r_clk;
    logic [CW-1:0]       r_count;
    logic [RAW_BITS-1:0] r_raw;

    // Captured tick.
    logic                r_end;
    logic                r_par;
    logic                r_sel;
    logic [RAW_BITS-1:0] r_raw_end;

    // Arithmetic stages.
    logic signed [8:0]                 r_angle;
    logic signed [sew_pkg::NUM_W-1:0]  r_num;
    logic [15:0]                       r_q0;
    logic                              r_zero;
    logic                              r_sat;

    // Output register.
    logic              r_out_valid;
    logic              r_o_sel;
    logic              r_o_clk;
    logic              r_o_av;
    logic signed [8:0] r_o_angle;
    logic [15:0]       r_o_width;
    logic              r_o_par;

    // Next frame state for the offered tick.
    logic [PW-1:0]       ph_next;
    logic                toggle;
    logic                fall;
    logic                frame_end;
    logic                sel_next;
    logic [PW-1:0]       n_phase;
    logic                n_clk;
    logic [CW-1:0]       n_count;
    logic [RAW_BITS-1:0] n_raw;

    always_comb begin
        ph_next   = r_phase + PW'(1);
        toggle    = (ph_next > PW'(1)) && (ph_next <= PW'(LAST_CLOCK_TICK));
        fall      = toggle && r_clk && (ph_next >= PW'(sew_pkg::FIRST_SAMPLE_TICK));
        frame_end = (ph_next == PW'(LAST_CLOCK_TICK + 1));
        sel_next  = !((ph_next >= PW'(1)) && (ph_next <= PW'(LAST_CLOCK_TICK)));
        n_phase   = (ph_next >= PW'(FRAME_TICKS)) ? '0 : ph_next;
        n_clk     = toggle ? ~r_clk : r_clk;
        n_count   = r_count;
        n_raw     = r_raw;
        if (fall) begin
            if (r_count < CW'(RAW_BITS)) begin
                n_raw = {r_raw[RAW_BITS-2:0], i_data_in};
            end
            if (r_count < CW'(sew_pkg::COUNT_MAX)) begin
                n_count = r_count + CW'(1);
            end
        end
        if (frame_end) begin
            n_count = '0;
            n_raw   = '0;
        end
    end

    // Raw word to degrees: floor(raw * 360 / 2^RAW_BITS), upper half wraps
    // to negative angles.
    logic [AP_W-1:0] ang_prod;
    logic [8:0]      ang_u;
    logic signed [8:0] n_angle;

    always_comb begin
        ang_prod = AP_W'(r_raw_end) * AP_W'(sew_pkg::DEG_FULL);
        ang_u    = ang_prod[AP_W-1:RAW_BITS];
        n_angle  = (ang_u > 9'(sew_pkg::DEG_HALF)) ? signed'(ang_u - 9'(sew_pkg::DEG_FULL))
                                                   : signed'(ang_u);
    end

    // Width numerator: center * 360 - angle * (right - left).
    logic signed [sew_pkg::SPAN_W-1:0] span;
    logic [24:0]                       c360;
    logic signed [25:0]                as_prod;
    logic signed [sew_pkg::NUM_W-1:0]  n_num;

    always_comb begin
        span    = $signed({1'b0, r_right}) - $signed({1'b0, r_left});
        c360    = 25'(r_center) * 25'(sew_pkg::DEG_FULL);
        as_prod = r_angle * span;
        n_num   = $signed({2'b00, c360}) - $signed({as_prod[25], as_prod});
    end

    // Reciprocal multiply gives the quotient or one less.
    logic [sew_pkg::RECIP_PROD_W-1:0] rp;

    assign rp = sew_pkg::RECIP_PROD_W'(r_num[sew_pkg::QNUM_W-1:0])
              * sew_pkg::RECIP_PROD_W'(sew_pkg::RECIP_MUL);

    // Correction step and saturation.
    logic [sew_pkg::QNUM_W-1:0] q0_x;
    logic [sew_pkg::QNUM_W-1:0] rem;
    logic [15:0]                q_fix;
    logic [15:0]                width_res;

    always_comb begin
        q0_x  = sew_pkg::QNUM_W'(r_q0) * sew_pkg::QNUM_W'(sew_pkg::DEG_FULL);
        rem   = r_num[sew_pkg::QNUM_W-1:0] - q0_x;
        q_fix = (rem >= sew_pkg::QNUM_W'(sew_pkg::DEG_FULL)) ? r_q0 + 16'd1 : r_q0;
        if (r_zero) begin
            width_res = '0;
        end else if (r_sat) begin
            width_res = '1;
        end else begin
            width_res = q_fix;
        end
    end

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center <= sew_pkg::CENTER_RST;
            r_left   <= sew_pkg::LEFT_RST;
            r_right  <= sew_pkg::RIGHT_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                sew_pkg::CFG_CENTER: r_center <= i_cfg_data;
                sew_pkg::CFG_LEFT:   r_left   <= i_cfg_data;
                sew_pkg::CFG_RIGHT:  r_right  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Frame state advances once per accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_clk   <= 1'b1;
            r_count <= '0;
            r_raw   <= '0;
        end else if (i_cmd.take) begin
            r_phase <= n_phase;
            r_clk   <= n_clk;
            r_count <= n_count;
            r_raw   <= n_raw;
        end
    end

    // Tick capture and arithmetic stages.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_end     <= frame_end;
            r_par     <= i_data_in;
            r_sel     <= sel_next;
            r_raw_end <= r_raw;
        end
        if (i_cmd.angle) begin
            r_angle <= n_angle;
        end
        if (i_cmd.num) begin
            r_num <= n_num;
        end
        if (i_cmd.recip) begin
            r_q0   <= rp[RS+15:RS];
            r_zero <= r_num[sew_pkg::NUM_W-1] || (r_num == '0);
            r_sat  <= (r_num >= sew_pkg::SAT_NUM);
        end
    end

    // Output register: holds one result until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_o_sel   <= r_sel;
            r_o_clk   <= r_clk;
            r_o_av    <= r_end;
            r_o_angle <= r_end ? r_angle : '0;
            r_o_width <= r_end ? width_res : '0;
            r_o_par   <= r_end & r_par;
        end
    end

    assign o_stat.frame_end = frame_end;
    assign o_stat.out_free  = !r_out_valid || !i_stall;

    assign o_valid       = r_out_valid;
    assign o_select_out  = r_o_sel;
    assign o_clock_out   = r_o_clk;
    assign o_angle_valid = r_o_av;
    assign o_angle_deg   = r_o_angle;
    assign o_servo_width = r_o_width;
    assign o_parity_bit  = r_o_par;

endmodule

// ----- hdl/ssi_encoder_to_servo_width_unit.sv -----
// SSI encoder reader with servo width output; one result per accepted tick.
// Ordinary ticks go from the tick capture to the output load; the frame-end
// tick first runs the sequencer's angle, numerator and divide steps.
// No new tick is taken until its result is loaded; the load waits on i_stall.
// Reset (i_rst_n low, synchronous) restores the configuration defaults, clears
// the frame position and the output valid flag, and leaves the serial clock high.
module ssi_encoder_to_servo_width_unit #(
    parameter int unsigned RAW_BITS        = sew_pkg::RAW_BITS_DEF,
    parameter int unsigned FRAME_TICKS     = sew_pkg::FRAME_TICKS_DEF,
    parameter int unsigned LAST_CLOCK_TICK = sew_pkg::LAST_CLOCK_TICK_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic              i_data_in,
    input  logic              i_cfg_wr_en,
    input  logic [1:0]        i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    output logic              o_valid,
    input  logic              i_stall,
    output logic              o_select_out,
    output logic              o_clock_out,
    output logic              o_angle_valid,
    output logic signed [8:0] o_angle_deg,
    output logic [15:0]       o_servo_width,
    output logic              o_parity_bit
);

    sew_pkg::t_cmd  cmd;
    sew_pkg::t_stat stat;

    // Sequencer.
    sew_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_stall (o_stall)
    );

    // Frame state, arithmetic and output register.
    sew_datapath #(
        .RAW_BITS        (RAW_BITS),
        .FRAME_TICKS     (FRAME_TICKS),
        .LAST_CLOCK_TICK (LAST_CLOCK_TICK)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_data_in     (i_data_in),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_select_out  (o_select_out),
        .o_clock_out   (o_clock_out),
        .o_angle_valid (o_angle_valid),
        .o_angle_deg   (o_angle_deg),
        .o_servo_width (o_servo_width),
        .o_parity_bit  (o_parity_bit)
    );

endmodule

// ----- hdl/sew_checker.sv -----
module sew_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              i_o_stall,
    input logic              i_o_valid,
    input logic              i_stall,
    input logic              i_select_out,
    input logic              i_angle_valid,
    input logic signed [8:0] i_angle_deg,
    input logic [15:0]       i_servo_width,
    input logic              i_parity_bit
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_o_valid && i_stall |=> i_o_valid)
        else $error("result dropped while stalled");

    // After a tick transfer the block is busy on the next cycle.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_o_stall |=> i_o_stall)
        else $error("tick taken while previous tick still in work");

    // Results outside the frame end carry no angle, width or parity.
    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_o_valid && !i_angle_valid |->
            (i_angle_deg == 9'sd0) && (i_servo_width == 16'd0) && !i_parity_bit)
        else $error("angle fields set outside the frame end");

    // The frame-end result has select raised.
    a_end_select: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_o_valid && i_angle_valid |-> i_select_out)
        else $error("frame end with select low");

endmodule

bind ssi_encoder_to_servo_width_unit sew_checker u_sew_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .i_o_stall     (o_stall),
    .i_o_valid     (o_valid),
    .i_stall       (i_stall),
    .i_select_out  (o_select_out),
    .i_angle_valid (o_angle_valid),
    .i_angle_deg   (o_angle_deg),
    .i_servo_width (o_servo_width),
    .i_parity_bit  (o_parity_bit)
);
